// ===== design/jmsp_pkg.sv =====
package jmsp_pkg;

    // Joint count and the fixed widths of the item fields.
    localparam int JOINT_COUNT_DEF = 6;
    localparam int ANGLE_W         = 15;
    localparam int SPEED_W         = 13;
    localparam int LEAD_W          = 3;
    localparam int PCT_W           = 7;
    localparam int CFG_IDX_W       = 1;

    // Internal arithmetic widths. An absolute angle change fits in 15 bits,
    // the change times a reduction in 21, and the scaled value in 30.
    localparam int MAG_W      = 15;
    localparam int GEAR_W     = 6;
    localparam int SCALE_W    = 9;
    localparam int DD_W       = 7;
    localparam int MUL_A_W    = 21;
    localparam int MUL_B_W    = 9;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int FRAC_SHIFT = 8;
    localparam int NUM_W      = MUL_P_W + FRAC_SHIFT;
    localparam int DEN_W      = MUL_P_W;
    localparam int QUO_W      = 14;

    localparam int SPEED_SAT = 8191;
    localparam int PCT_MAX   = 100;
    localparam int DD_NORMAL = 10;
    localparam int DD_CONT   = 100;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_MOVE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_PERCENT = 1'b0,
        CFG_CONTINUOUS    = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Joint windows are held in sixteenths of a degree.
    function automatic logic signed [ANGLE_W-1:0] angle_lo(input logic [LEAD_W-1:0] j);
        logic signed [ANGLE_W-1:0] v;
        case (j)
            3'd0:    v = -15'sd2720;
            3'd1:    v = -15'sd1168;
            3'd2:    v = 15'sd560;
            3'd3:    v = -15'sd2880;
            3'd4:    v = -15'sd1920;
            default: v = -15'sd11520;
        endcase
        return v;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] angle_hi(input logic [LEAD_W-1:0] j);
        logic signed [ANGLE_W-1:0] v;
        case (j)
            3'd0:    v = 15'sd2720;
            3'd1:    v = 15'sd1440;
            3'd2:    v = 15'sd2880;
            3'd3:    v = 15'sd2880;
            3'd4:    v = 15'sd1920;
            default: v = 15'sd11520;
        endcase
        return v;
    endfunction

    function automatic logic [GEAR_W-1:0] gear_ratio(input logic [LEAD_W-1:0] j);
        logic [GEAR_W-1:0] v;
        case (j)
            3'd3:    v = 6'd24;
            3'd5:    v = 6'd50;
            default: v = 6'd30;
        endcase
        return v;
    endfunction

endpackage

// ===== design/jmsp_div.sv =====
module jmsp_div
    import jmsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_ctrl_t        ctrl,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output div_stat_t        stat,
    output logic [QUO_W-1:0] quo
);

    localparam int SH_W  = DEN_W + QUO_W - 1;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [NUM_W-1:0] rem_reg;
    logic [SH_W-1:0]  den_sh_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             fits;
    logic [NUM_W-1:0] rem_sub;

    // One restoring step a cycle, most significant quotient bit first.
    always_comb
    begin
        fits    = {{(SH_W - NUM_W){1'b0}}, rem_reg} >= den_sh_reg;
        rem_sub = rem_reg - den_sh_reg[NUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg    <= num;
            den_sh_reg <= {den, {(QUO_W - 1){1'b0}}};
            quo_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_sub;
            end
            quo_reg    <= {quo_reg[QUO_W-2:0], fits};
            den_sh_reg <= den_sh_reg >> 1;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule

// ===== design/joint_move_speed_planner.sv =====
// Synchronised multi-joint move speed planner.
// Items arrive on the s_axis channel: tuser selects a load of the current
// joint angles (0) or a move to target angles (1), tdata carries one signed
// angle per joint in sixteenths of a degree. Each item gives exactly one
// result item on the m_axis channel: tuser says whether the move was taken,
// tdata carries the lead joint and one speed per joint in 1/256 rev/s.
// The cfg channel writes the speed percent (index 0) and the continuous mode
// flag (index 1); it is always ready. The user is bound to write it only
// while idle; the block itself does not enforce this. A load item or a
// rejected move goes from the check straight to the finishing state, a move
// in which no joint changes does so after the scan for the largest change.
// Any other accepted move goes on from that scan: one shared multiplier and
// one 14-step restoring divider work through the joints one after another.
// s_axis_tready is low while an item is being worked on.
// A finished result waits in the output register while the receiver stalls;
// the next item may be accepted meanwhile, but its result is held back until
// the previous one has been taken.
// Reset clears the configuration, the stored angles and the output valid.
module joint_move_speed_planner
    import jmsp_pkg::*;
#(
    parameter int JOINT_COUNT = JOINT_COUNT_DEF,
    localparam int IN_DATA_W  = ((ANGLE_W * JOINT_COUNT + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((LEAD_W + SPEED_W * JOINT_COUNT + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // angle_0, angle_1, ... (15 bits each)
    input  logic                  s_axis_tuser,   // func
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // lead_joint, speed_0, speed_1, ...
    output logic                  m_axis_tuser,   // accepted
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [PCT_W-1:0]      cfg_data
);

    localparam int IDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DEN_A,
        ST_DEN_B,
        ST_NUM_A,
        ST_NUM_B,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t state_reg;

    logic [PCT_W-1:0] pct_reg;
    logic             cont_reg;

    logic signed [ANGLE_W-1:0] cur_angle_reg [JOINT_COUNT];
    logic signed [ANGLE_W-1:0] tgt_angle_reg [JOINT_COUNT];
    logic signed [ANGLE_W-1:0] in_angle_reg  [JOINT_COUNT];
    logic                      func_reg;

    logic [MAG_W-1:0]   mag_reg   [JOINT_COUNT];
    logic [MAG_W-1:0]   mag_next  [JOINT_COUNT];
    logic [SPEED_W-1:0] speed_reg [JOINT_COUNT];
    logic [MAG_W-1:0]   max_reg;
    logic [IDX_W-1:0]   lead_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               acc_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [DD_W-1:0]    dd_reg;
    logic [MUL_A_W-1:0] prod_reg;
    logic [DEN_W-1:0]   den_reg;

    logic                  out_valid_reg;
    logic                  out_user_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    logic               violation;
    logic [PCT_W-1:0]   pct_clamped;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;
    logic [LEAD_W-1:0]  idx_wide;
    logic               last_joint;
    logic [SPEED_W-1:0] speed_sat;

    div_ctrl_t        div_ctrl;
    div_stat_t        div_stat;
    logic [QUO_W-1:0] div_quo;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tdata  = out_data_reg;

    assign idx_wide    = LEAD_W'(idx_reg);
    assign last_joint  = (idx_reg == IDX_W'(JOINT_COUNT - 1));
    assign pct_clamped = (pct_reg > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : pct_reg;

    // The quotient stays well below 2^14 for any legal setting, since the
    // change of a joint never exceeds the lead change.
    assign speed_sat = (div_quo > QUO_W'(SPEED_SAT)) ? SPEED_W'(SPEED_SAT)
                                                     : div_quo[SPEED_W-1:0];

    always_comb
    begin
        violation = 1'b0;
        for (int j = 0; j < JOINT_COUNT; j++)
        begin
            if (in_angle_reg[j] > angle_hi(LEAD_W'(j)) ||
                in_angle_reg[j] < angle_lo(LEAD_W'(j)))
            begin
                violation = 1'b1;
            end
        end
    end

    always_comb
    begin
        logic signed [ANGLE_W:0] diff;
        for (int j = 0; j < JOINT_COUNT; j++)
        begin
            diff = {in_angle_reg[j][ANGLE_W-1], in_angle_reg[j]}
                 - {cur_angle_reg[j][ANGLE_W-1], cur_angle_reg[j]};
            mag_next[j] = diff[ANGLE_W] ? MAG_W'(-diff) : MAG_W'(diff);
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (state_reg)
            ST_DEN_A:
            begin
                mul_a = MUL_A_W'(max_reg);
                mul_b = MUL_B_W'(gear_ratio(LEAD_W'(lead_reg)));
            end
            ST_DEN_B:
            begin
                mul_a = prod_reg;
                mul_b = MUL_B_W'(dd_reg);
            end
            ST_NUM_A:
            begin
                mul_a = MUL_A_W'(mag_reg[idx_reg]);
                mul_b = MUL_B_W'(gear_ratio(idx_wide));
            end
            ST_NUM_B:
            begin
                mul_a = prod_reg;
                mul_b = scale_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    end

    always_comb
    begin
        out_data_next = '0;
        out_data_next[LEAD_W-1:0] = LEAD_W'(lead_reg);
        for (int j = 0; j < JOINT_COUNT; j++)
        begin
            out_data_next[LEAD_W + SPEED_W * j +: SPEED_W] = speed_reg[j];
        end
    end

    assign div_ctrl.start = (state_reg == ST_NUM_B) && !div_stat.busy;

    jmsp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .num   ({mul_p, {FRAC_SHIFT{1'b0}}}),
        .den   (den_reg),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pct_reg  <= '0;
            cont_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SPEED_PERCENT: pct_reg  <= cfg_data;
                CFG_CONTINUOUS:    cont_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            func_reg <= s_axis_tuser;
            for (int j = 0; j < JOINT_COUNT; j++)
            begin
                in_angle_reg[j] <= s_axis_tdata[ANGLE_W * j +: ANGLE_W];
            end
        end
    end

    // Sequencer: state, stored angles, working registers and the output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < JOINT_COUNT; j++)
            begin
                cur_angle_reg[j] <= '0;
                tgt_angle_reg[j] <= '0;
            end
        end
        else
        begin
            // In the finishing state the output register is reloaded below instead.
            if (out_valid_reg && m_axis_tready && state_reg != ST_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    lead_reg  <= '0;
                    max_reg   <= '0;
                    idx_reg   <= '0;
                    scale_reg <= cont_reg ? SCALE_W'({pct_clamped, 1'b0}) + SCALE_W'(pct_clamped)
                                          : SCALE_W'(pct_clamped);
                    dd_reg    <= cont_reg ? DD_W'(DD_CONT) : DD_W'(DD_NORMAL);
                    for (int j = 0; j < JOINT_COUNT; j++)
                    begin
                        speed_reg[j] <= '0;
                        mag_reg[j]   <= mag_next[j];
                    end
                    if (func_reg == FUNC_LOAD)
                    begin
                        for (int j = 0; j < JOINT_COUNT; j++)
                        begin
                            cur_angle_reg[j] <= in_angle_reg[j];
                        end
                        acc_reg   <= 1'b1;
                        state_reg <= ST_FINISH;
                    end
                    else if (violation)
                    begin
                        acc_reg   <= 1'b0;
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        acc_reg   <= 1'b1;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    // Strictly greater, so the lowest index wins a tie.
                    if (mag_reg[idx_reg] > max_reg)
                    begin
                        max_reg  <= mag_reg[idx_reg];
                        lead_reg <= idx_reg;
                    end
                    if (last_joint)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_DEN_A;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DEN_A:
                begin
                    if (max_reg == '0)
                    begin
                        lead_reg <= '0;
                        for (int j = 0; j < JOINT_COUNT; j++)
                        begin
                            tgt_angle_reg[j] <= in_angle_reg[j];
                        end
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        prod_reg  <= mul_p[MUL_A_W-1:0];
                        state_reg <= ST_DEN_B;
                    end
                end
                ST_DEN_B:
                begin
                    den_reg   <= mul_p;
                    state_reg <= ST_NUM_A;
                end
                ST_NUM_A:
                begin
                    prod_reg  <= mul_p[MUL_A_W-1:0];
                    state_reg <= ST_NUM_B;
                end
                ST_NUM_B:
                begin
                    if (!div_stat.busy)
                    begin
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    if (div_stat.done)
                    begin
                        speed_reg[idx_reg] <= speed_sat;
                        if (last_joint)
                        begin
                            for (int j = 0; j < JOINT_COUNT; j++)
                            begin
                                tgt_angle_reg[j] <= in_angle_reg[j];
                            end
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_NUM_A;
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_user_reg  <= acc_reg;
                        out_data_reg  <= out_data_next;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/jmsp_check.sv =====
module jmsp_check
    import jmsp_pkg::*;
#(
    parameter int JOINT_COUNT = JOINT_COUNT_DEF,
    localparam int IN_DATA_W  = ((ANGLE_W * JOINT_COUNT + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((LEAD_W + SPEED_W * JOINT_COUNT + 7) / 8) * 8
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic                  s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [PCT_W-1:0]      cfg_data
);

    // A result that is not taken stays on offer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed or dropped");

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready straight after an accepted item");

    // A rejected move carries no lead joint and no speeds.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("rejected move with non-zero payload");

    a_lead_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> {1'b0, m_axis_tdata[LEAD_W-1:0]} < (LEAD_W + 1)'(JOINT_COUNT))
        else $error("lead joint beyond the joint count");

    // No result without an item: a fresh result needs the block to have been busy.
    a_result_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while the block was idle");

endmodule

bind joint_move_speed_planner jmsp_check #(.JOINT_COUNT(JOINT_COUNT)) u_check (.*);

// ===== test/jmsp_checker.sv =====
module jmsp_checker
    import jmsp_pkg::*;
#(
    parameter int JOINTS     = JOINT_COUNT_DEF,
    localparam int IN_W      = ((ANGLE_W * JOINTS + 7) / 8) * 8,
    localparam int OUT_W     = ((LEAD_W + SPEED_W * JOINTS + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,
    input  logic                 s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [OUT_W-1:0]     m_axis_tdata,
    input  logic                 m_axis_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PCT_W-1:0]     cfg_data,
    input  logic                 wrap_up,
    output int                   fail_count,
    output int                   outstanding,
    output int                   loads_seen,
    output int                   moves_taken,
    output int                   moves_refused,
    output int                   results_checked
);

    typedef struct packed {
        logic                            accepted;
        logic [LEAD_W-1:0]               lead;
        logic [JOINTS-1:0][SPEED_W-1:0]  speed;
    } plan_t;

    // Joint windows in whole degrees and the gear reductions.
    localparam int WIN_LO [8] = '{-170, -73, 35, -180, -120, -720, -720, -720};
    localparam int WIN_HI [8] = '{170, 90, 180, 180, 120, 720, 720, 720};
    localparam int GEAR   [8] = '{30, 30, 30, 24, 30, 50, 30, 30};

    logic [PCT_W-1:0] pct_reg;
    logic             cont_reg;
    int               cur_angle [JOINTS];
    int               tgt_angle [JOINTS];
    plan_t            plans_due [$];
    int               items_in;
    int               items_out;
    logic             wrapped;

    assign outstanding = items_in - items_out;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic plan_t plan_item(input logic fn, input logic [IN_W-1:0] data);
        plan_t             res;
        int                tgt [JOINTS];
        int                mag [JOINTS];
        int                peak;
        int                lead;
        logic              in_window;
        longint unsigned   pct;
        longint unsigned   kf;
        longint unsigned   dd;
        longint unsigned   num;
        longint unsigned   den;
        longint unsigned   spd;
        res = '0;
        for (int j = 0; j < JOINTS; j++)
            tgt[j] = signed'(data[ANGLE_W*j +: ANGLE_W]);
        if (fn == FUNC_LOAD)
        begin
            for (int j = 0; j < JOINTS; j++)
                cur_angle[j] = tgt[j];
            res.accepted = 1'b1;
            return res;
        end
        in_window = 1'b1;
        for (int j = 0; j < JOINTS; j++)
            if (tgt[j] > WIN_HI[j] * 16 || tgt[j] < WIN_LO[j] * 16)
                in_window = 1'b0;
        if (!in_window)
            return res;
        // The first joint with the largest change leads; later ties do not replace it.
        peak = 0;
        lead = 0;
        for (int j = 0; j < JOINTS; j++)
        begin
            mag[j] = tgt[j] - cur_angle[j];
            if (mag[j] < 0)
                mag[j] = -mag[j];
            if (mag[j] > peak)
            begin
                peak = mag[j];
                lead = j;
            end
        end
        res.accepted = 1'b1;
        res.lead     = LEAD_W'(lead);
        if (peak != 0)
        begin
            pct = (pct_reg > PCT_W'(100)) ? 100 : longint'(pct_reg);
            kf  = cont_reg ? 3 : 1;
            dd  = cont_reg ? 100 : 10;
            den = dd * longint'(peak) * longint'(GEAR[lead]);
            for (int j = 0; j < JOINTS; j++)
            begin
                num = 256 * pct * kf * longint'(mag[j]) * longint'(GEAR[j]);
                spd = num / den;
                if (spd > 8191)
                    spd = 8191;
                res.speed[j] = SPEED_W'(spd);
            end
        end
        for (int j = 0; j < JOINTS; j++)
            tgt_angle[j] = tgt[j];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        plan_t want;
        plan_t got;
        if (!rst_n)
        begin
            pct_reg         <= '0;
            cont_reg        <= 1'b0;
            items_in        <= 0;
            items_out       <= 0;
            wrapped         <= 1'b0;
            fail_count      = 0;
            loads_seen      = 0;
            moves_taken     = 0;
            moves_refused   = 0;
            results_checked = 0;
            plans_due.delete();
            for (int j = 0; j < JOINTS; j++)
            begin
                cur_angle[j] = 0;
                tgt_angle[j] = 0;
            end
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                items_out <= items_out + 1;
                if (plans_due.size() == 0)
                    report_mismatch("result item with nothing pending", 1, 0);
                else
                begin
                    want = plans_due.pop_front();
                    // The lead joint sits in the lowest bits, the speeds above it.
                    got          = '0;
                    got.accepted = m_axis_tuser;
                    got.lead     = m_axis_tdata[LEAD_W-1:0];
                    for (int j = 0; j < JOINTS; j++)
                        got.speed[j] = m_axis_tdata[LEAD_W + SPEED_W*j +: SPEED_W];
                    results_checked++;
                    if (got.accepted != want.accepted)
                        report_mismatch("accepted", got.accepted, want.accepted);
                    if (got.lead != want.lead)
                        report_mismatch("lead_joint", got.lead, want.lead);
                    for (int j = 0; j < JOINTS; j++)
                        if (got.speed[j] != want.speed[j])
                            report_mismatch($sformatf("speed_%0d", j),
                                            got.speed[j], want.speed[j]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = plan_item(s_axis_tuser, s_axis_tdata);
                plans_due.push_back(want);
                items_in <= items_in + 1;
                if (s_axis_tuser == FUNC_LOAD)
                    loads_seen++;
                else if (want.accepted)
                    moves_taken++;
                else
                    moves_refused++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_SPEED_PERCENT: pct_reg  <= cfg_data;
                    CFG_CONTINUOUS:    cont_reg <= cfg_data[0];
                    default:           ;
                endcase
            end
            if (wrap_up && !wrapped)
            begin
                wrapped <= 1'b1;
                if (plans_due.size() != 0)
                    report_mismatch("results never delivered", 0, plans_due.size());
            end
        end
    end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    import jmsp_pkg::*;

    localparam int JOINTS      = JOINT_COUNT_DEF;
    localparam int IN_W        = ((ANGLE_W * JOINTS + 7) / 8) * 8;
    localparam int OUT_W       = ((LEAD_W + SPEED_W * JOINTS + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 600;
    localparam int BLOCK_ITEMS = 75;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata  = '0;   // angle_0, angle_1, ... (15 bits each)
    logic                 s_axis_tuser  = 1'b0; // func
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;         // lead_joint, speed_0, speed_1, ...
    logic                 m_axis_tuser;         // accepted
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [PCT_W-1:0]     cfg_data      = '0;

    logic wrap_up   = 1'b0;
    logic hold_req  = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;
    int   tx_idle_pct = 10;
    int   rx_idle_pct = 71;
    int   cycle_count = 0;
    int   settings_used = 0;
    logic [IN_W-1:0] last_load = '0;

    int fail_count;
    int outstanding;
    int loads_seen;
    int moves_taken;
    int moves_refused;
    int results_checked;

    joint_move_speed_planner u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    jmsp_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .wrap_up         (wrap_up),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .loads_seen      (loads_seen),
        .moves_taken     (moves_taken),
        .moves_refused   (moves_refused),
        .results_checked (results_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: a toggle of hold_req starts a long hold-off, otherwise random stalls.
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen     <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic logic [IN_W-1:0] pack_angles(input int a0, input int a1, input int a2,
                                                    input int a3, input int a4, input int a5);
        logic [IN_W-1:0] data;
        data = '0;
        data[ANGLE_W*0 +: ANGLE_W] = ANGLE_W'(a0);
        data[ANGLE_W*1 +: ANGLE_W] = ANGLE_W'(a1);
        data[ANGLE_W*2 +: ANGLE_W] = ANGLE_W'(a2);
        data[ANGLE_W*3 +: ANGLE_W] = ANGLE_W'(a3);
        data[ANGLE_W*4 +: ANGLE_W] = ANGLE_W'(a4);
        data[ANGLE_W*5 +: ANGLE_W] = ANGLE_W'(a5);
        return data;
    endfunction

    // Mostly inside the joint window, sometimes right on its edges.
    function automatic logic [ANGLE_W-1:0] window_angle(input int j);
        int lo;
        int hi;
        int r;
        lo = angle_lo(LEAD_W'(j));
        hi = angle_hi(LEAD_W'(j));
        r  = $urandom_range(99);
        if (r < 5)
            return ANGLE_W'(lo);
        if (r < 10)
            return ANGLE_W'(hi);
        return ANGLE_W'(lo + int'($urandom_range(hi - lo)));
    endfunction

    task automatic send_item(input logic fn, input logic [IN_W-1:0] data);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= fn;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_config(input int pct, input int cont);
        wait_for_results();
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SPEED_PERCENT;
        cfg_data  <= PCT_W'(pct);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_CONTINUOUS;
        cfg_data  <= PCT_W'(cont);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_random(input int count);
        logic            fn;
        logic [IN_W-1:0] data;
        int              shape;
        int              bad;
        logic [ANGLE_W-1:0] prev;
        for (int i = 0; i < count; i++)
        begin
            fn    = ($urandom_range(99) < 25) ? FUNC_LOAD : FUNC_MOVE;
            shape = $urandom_range(99);
            bad   = $urandom_range(JOINTS - 1);
            data  = '0;
            for (int j = 0; j < JOINTS; j++)
            begin
                prev = last_load[ANGLE_W*j +: ANGLE_W];
                if (fn == FUNC_LOAD)
                    data[ANGLE_W*j +: ANGLE_W] = (shape < 20) ?
                        ANGLE_W'($urandom_range(32767)) : window_angle(j);
                else if (shape < 15 && j == bad)
                    data[ANGLE_W*j +: ANGLE_W] = ANGLE_W'($urandom_range(32767));
                else if (shape >= 15 && shape < 30 && $urandom_range(1) == 1 &&
                         $signed(prev) >= angle_lo(LEAD_W'(j)) &&
                         $signed(prev) <= angle_hi(LEAD_W'(j)))
                    // Unchanged joints give zero or tied changes.
                    data[ANGLE_W*j +: ANGLE_W] = prev;
                else
                    data[ANGLE_W*j +: ANGLE_W] = window_angle(j);
            end
            if (fn == FUNC_LOAD)
                last_load = data;
            send_item(fn, data);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        set_config(PCT_MAX, 0);
        send_item(FUNC_MOVE, pack_angles(0, 0, 560, 0, 0, 0));
        send_item(FUNC_MOVE, pack_angles(0, 0, 0, 0, 0, 0));
        send_item(FUNC_LOAD, pack_angles(16383, 16383, 16383, 16383, 16383, 16383));
        send_item(FUNC_MOVE, pack_angles(-2720, -1168, 560, -2880, -1920, -11520));
        send_item(FUNC_LOAD, pack_angles(-16384, -16384, -16384, -16384, -16384, -16384));
        send_item(FUNC_MOVE, pack_angles(2720, 1440, 2880, 2880, 1920, 11520));
        send_item(FUNC_MOVE, pack_angles(2721, 0, 560, 0, 0, 0));
        send_item(FUNC_MOVE, pack_angles(0, -1169, 560, 0, 0, 0));
        send_item(FUNC_MOVE, pack_angles(0, 0, 2881, 0, 0, 0));
        send_item(FUNC_MOVE, pack_angles(0, 0, 559, 0, 0, 0));
        send_item(FUNC_MOVE, pack_angles(0, 0, 560, 0, 1921, 0));
        send_item(FUNC_MOVE, pack_angles(0, 0, 560, 0, 0, -11521));
        send_item(FUNC_MOVE, pack_angles(-16384, -16384, -16384, -16384, -16384, -16384));
        send_item(FUNC_LOAD, pack_angles(0, 0, 0, 0, 0, 0));
        // Joints 1 and 4 tie for the largest change.
        send_item(FUNC_MOVE, pack_angles(300, 1000, 600, -200, 1000, 0));
        send_item(FUNC_MOVE, pack_angles(0, 0, 1000, 2880, 0, 2880));
        send_item(FUNC_MOVE, pack_angles(0, 0, 1000, 2880, 0, 2880));
        set_config(127, 1);
        send_item(FUNC_MOVE, pack_angles(0, 0, 1000, 2880, 0, 2880));
        send_item(FUNC_LOAD, pack_angles(5, -7, 560, 11, 0, -3));
        send_item(FUNC_MOVE, pack_angles(5, -7, 560, 11, 0, -3));
        send_item(FUNC_MOVE, pack_angles(2720, -1168, 2880, -2880, 1920, 11520));
        set_config(0, 0);
        send_item(FUNC_MOVE, pack_angles(100, 200, 900, -400, 50, 7000));
        last_load = pack_angles(5, -7, 560, 11, 0, -3);

        // Random part: six blocks, two per idling pattern, each with its own setting.
        tx_idle_pct = 10;
        rx_idle_pct = 71;
        set_config(PCT_MAX, 0);
        run_random(BLOCK_ITEMS);
        set_config(0, 1);
        run_random(BLOCK_ITEMS);

        tx_idle_pct = 71;
        rx_idle_pct = 10;
        set_config(127, 1);
        run_random(BLOCK_ITEMS / 2);
        wait_for_results();
        run_random(BLOCK_ITEMS - BLOCK_ITEMS / 2);
        set_config($urandom_range(99, 1), 0);
        run_random(BLOCK_ITEMS);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_config(1, 1);
        // The result side holds off while moves keep coming, so the input backs up.
        hold_req <= ~hold_req;
        run_random(BLOCK_ITEMS);
        set_config($urandom_range(PCT_MAX), $urandom_range(1));
        run_random(BLOCK_ITEMS);

        wait_for_results();
        repeat (150) @(posedge clk);
        wrap_up <= 1'b1;
        repeat (2) @(posedge clk);

        $display("Checked %0d results: %0d loads, %0d moves taken, %0d moves refused",
                 results_checked, loads_seen, moves_taken, moves_refused);
        $display("Ran under %0d speed settings with three idling patterns and a long hold-off",
                 settings_used);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
